@@ rtl/core/rftf_pkg.sv @@
// Package for the radio frequency tracking filter.
// Holds configuration types, register indexes, step codes and the FIR weight table.
// No dependencies.
package rftf_pkg;

  localparam int FILTER_TAPS = 11;
  localparam int TAP_W       = 4;
  localparam int DIV_STEPS   = 26;
  localparam int CNT_W       = 5;

  localparam logic [13:0] PPM_SCALE = 14'd15625;

  localparam logic [15:0] UPDATE_INTERVAL_RST  = 16'd15;
  localparam logic [14:0] PPM_THRESHOLD_RST    = 15'd1000;
  localparam logic [7:0]  CHIP_ERROR_LIMIT_RST = 8'd25;
  localparam logic [11:0] IF_HIGH_BOUND_RST    = 12'd520;
  localparam logic [11:0] IF_LOW_BOUND_RST     = 12'd480;
  localparam logic [11:0] IF_IDLE_VALUE        = 12'd500;

  localparam logic [2:0] REG_UPDATE_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_PPM_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_CHIP_ERROR_LIMIT = 3'd2;
  localparam logic [2:0] REG_IF_HIGH_BOUND    = 3'd3;
  localparam logic [2:0] REG_IF_LOW_BOUND     = 3'd4;

  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_UP   = 2'b01;
  localparam logic [1:0] STEP_DOWN = 2'b11;

  typedef struct packed {
    logic [15:0] update_interval;
    logic [14:0] ppm_threshold;
    logic [7:0]  chip_error_limit;
    logic [11:0] if_high_bound;
    logic [11:0] if_low_bound;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_MAC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic             push;
    logic             mac_step;
    logic             finish;
    logic [TAP_W-1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } status_t;

  // symmetric low-pass weights, sum 512
  function automatic logic [6:0] fir_weight(logic [TAP_W-1:0] tap);
    logic [6:0] w;
    case (tap) inside
      4'd0, 4'd10: w = 7'd4;
      4'd1, 4'd9:  w = 7'd16;
      4'd2, 4'd8:  w = 7'd37;
      4'd3, 4'd7:  w = 7'd64;
      4'd4, 4'd6:  w = 7'd87;
      4'd5:        w = 7'd96;
      default:     w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/radio_frequency_tracking_filter.sv @@
// Radio frequency tracking filter, top level.
// Depends on rftf_pkg, rftf_regs, rftf_ctrl and rftf_dp.
//
// One input transfer per received packet carries the IF estimate, chip error
// count, clock-recovery drift count and packet length. One output transfer
// returns the filtered ppm error, the filtered IF estimate with its taken
// flag, and the IF fine and LO channel code steps (+1, -1 or 0).
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. Configuration goes through the APB-style port, registers at
// byte addresses 0, 4, 8, 12 and 16; write only while no packet is in flight.
//
// Sequence: after the input transfer, the bit-serial ppm divider runs, the
// sample is pushed into the history, the shared multiply-accumulate steps
// over the taps and the result is formed. The input stays stalled through
// the divider and tap loop, so a new packet is taken only after the finish.
// The output register holds a finished result while the receiver stalls;
// the next packet is taken and processed meanwhile, and its result waits in
// the last step until the output register frees up.
// Reset loads the register defaults, clears the error history and cooldown
// count and fills every IF history tap but the last with its idle value, the last with zero.
module radio_frequency_tracking_filter
  import rftf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [11:0]        if_estimate_i,
  input  logic [7:0]         chip_errors_i,
  input  logic signed [15:0] drift_count_i,
  input  logic [6:0]         packet_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] rate_error_filtered_o,
  output logic [11:0]        if_filtered_o,
  output logic               sample_taken_o,
  output logic signed [1:0]  if_fine_step_o,
  output logic signed [1:0]  channel_code_step_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  rftf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rftf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rftf_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .cmd_i                 (cmd),
    .status_o              (status),
    .if_estimate_i         (if_estimate_i),
    .chip_errors_i         (chip_errors_i),
    .drift_count_i         (drift_count_i),
    .packet_length_i       (packet_length_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .rate_error_filtered_o (rate_error_filtered_o),
    .if_filtered_o         (if_filtered_o),
    .sample_taken_o        (sample_taken_o),
    .if_fine_step_o        (if_fine_step_o),
    .channel_code_step_o   (channel_code_step_o)
  );

endmodule

@@ rtl/core/rftf_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on rftf_pkg for cfg_t, reset values and register indexes.
module rftf_regs
  import rftf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:2])
        REG_UPDATE_INTERVAL:  cfg_d.update_interval  = pwdata[15:0];
        REG_PPM_THRESHOLD:    cfg_d.ppm_threshold    = pwdata[14:0];
        REG_CHIP_ERROR_LIMIT: cfg_d.chip_error_limit = pwdata[7:0];
        REG_IF_HIGH_BOUND:    cfg_d.if_high_bound    = pwdata[11:0];
        REG_IF_LOW_BOUND:     cfg_d.if_low_bound     = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_UPDATE_INTERVAL:  prdata = {16'd0, cfg_q.update_interval};
      REG_PPM_THRESHOLD:    prdata = {17'd0, cfg_q.ppm_threshold};
      REG_CHIP_ERROR_LIMIT: prdata = {24'd0, cfg_q.chip_error_limit};
      REG_IF_HIGH_BOUND:    prdata = {20'd0, cfg_q.if_high_bound};
      REG_IF_LOW_BOUND:     prdata = {20'd0, cfg_q.if_low_bound};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.update_interval  <= UPDATE_INTERVAL_RST;
      cfg_q.ppm_threshold    <= PPM_THRESHOLD_RST;
      cfg_q.chip_error_limit <= CHIP_ERROR_LIMIT_RST;
      cfg_q.if_high_bound    <= IF_HIGH_BOUND_RST;
      cfg_q.if_low_bound     <= IF_LOW_BOUND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/rftf_ctrl.sv @@
// Sequencer for one packet: load, divide, push sample, MAC over the taps, finish.
// Depends on rftf_pkg for state_e, cmd_t and status_t.
module rftf_ctrl
  import rftf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.tap  = cnt_q[TAP_W-1:0];
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        cnt_d      = '0;
        state_d    = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FILTER_TAPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!status_i.out_hold) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/rftf_dp.sv @@
// Datapath: ppm divider, both FIR histories and accumulators, cooldown and result register.
// Depends on rftf_pkg for cfg_t, cmd_t, status_t, step codes and fir_weight.
module rftf_dp
  import rftf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [11:0]        if_estimate_i,
  input  logic [7:0]         chip_errors_i,
  input  logic signed [15:0] drift_count_i,
  input  logic [6:0]         packet_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] rate_error_filtered_o,
  output logic [11:0]        if_filtered_o,
  output logic               sample_taken_o,
  output logic signed [1:0]  if_fine_step_o,
  output logic signed [1:0]  channel_code_step_o
);

  // divider
  logic [15:0] drift_abs;
  logic [29:0] prod;
  logic [25:0] dividend_q;
  logic [6:0]  rem_q;
  logic [15:0] quot_q;
  logic [6:0]  len_q;
  logic        neg_q;
  logic        taken_q;
  logic [7:0]  trial;
  logic        ge;
  logic [15:0] sample;

  // filters
  logic signed [15:0] rate_hist_q [FILTER_TAPS];
  logic [11:0]        if_hist_q   [FILTER_TAPS];
  logic signed [25:0] rate_acc_q;
  logic [20:0]        if_acc_q;
  logic [6:0]         w;
  logic signed [15:0] rate_sel;
  logic signed [23:0] rate_prod;
  logic [18:0]        if_prod;
  logic [15:0]        cooldown_q;

  // finish
  logic signed [25:0] rate_rnd;
  logic signed [15:0] filt;
  logic signed [16:0] filt_x, thr_pos, thr_neg;
  logic [11:0]        if_filt;
  logic               at_int;
  logic [1:0]         fine, code;

  logic               out_valid_q;
  logic signed [15:0] out_rate_q;
  logic [11:0]        out_if_q;
  logic               out_taken_q;
  logic [1:0]         out_fine_q, out_code_q;

  assign drift_abs = drift_count_i[15] ? 16'(~drift_count_i + 16'sd1) : drift_count_i;
  assign prod      = 30'(drift_abs) * 30'(PPM_SCALE);

  assign trial  = {rem_q, dividend_q[25]};
  assign ge     = trial >= {1'b0, len_q};
  assign sample = (len_q == 7'd0) ? 16'd0 : (neg_q ? 16'(-quot_q) : quot_q);

  assign w         = fir_weight(cmd_i.tap);
  assign rate_sel  = rate_hist_q[cmd_i.tap];
  assign rate_prod = rate_sel * $signed({1'b0, w});
  assign if_prod   = if_hist_q[cmd_i.tap] * w;

  // truncate toward zero on the divide by 512
  assign rate_rnd = rate_acc_q + (rate_acc_q[25] ? 26'sd511 : 26'sd0);
  assign filt     = rate_rnd[24:9];
  assign filt_x   = {filt[15], filt};
  assign thr_pos  = {2'b00, cfg_i.ppm_threshold};
  assign thr_neg  = -thr_pos;
  assign if_filt  = if_acc_q[20:9];
  assign at_int   = cooldown_q == cfg_i.update_interval;

  always_comb begin
    fine = STEP_NONE;
    if (at_int && filt_x > thr_pos) fine = STEP_UP;
    if (at_int && filt_x < thr_neg) fine = STEP_DOWN;
    code = STEP_NONE;
    if (taken_q && at_int) begin
      if (if_filt > cfg_i.if_high_bound) code = STEP_UP;
      if (if_filt < cfg_i.if_low_bound)  code = STEP_DOWN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dividend_q <= prod[28:3];
      rem_q      <= '0;
      quot_q     <= '0;
      len_q      <= packet_length_i;
      neg_q      <= drift_count_i[15];
      taken_q    <= chip_errors_i < cfg_i.chip_error_limit;
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[24:0], 1'b0};
      rem_q      <= ge ? 7'(trial - {1'b0, len_q}) : trial[6:0];
      quot_q     <= {quot_q[14:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      rate_acc_q <= '0;
      if_acc_q   <= '0;
    end else if (cmd_i.mac_step) begin
      rate_acc_q <= rate_acc_q + {{2{rate_prod[23]}}, rate_prod};
      if_acc_q   <= if_acc_q + 21'(if_prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FILTER_TAPS; k++) begin
        rate_hist_q[k] <= '0;
        if_hist_q[k]   <= (k < FILTER_TAPS - 1) ? IF_IDLE_VALUE : 12'd0;
      end
      cooldown_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cooldown_q <= cooldown_q + 16'd1;
        if (chip_errors_i < cfg_i.chip_error_limit) begin
          for (int k = FILTER_TAPS - 1; k > 0; k--) begin
            if_hist_q[k] <= if_hist_q[k-1];
          end
          if_hist_q[0] <= if_estimate_i;
        end
      end
      if (cmd_i.push) begin
        for (int k = FILTER_TAPS - 1; k > 0; k--) begin
          rate_hist_q[k] <= rate_hist_q[k-1];
        end
        rate_hist_q[0] <= sample;
      end
      if (cmd_i.finish && taken_q && at_int) begin
        cooldown_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_rate_q  <= filt;
      out_if_q    <= taken_q ? if_filt : 12'd0;
      out_taken_q <= taken_q;
      out_fine_q  <= fine;
      out_code_q  <= code;
    end
  end

  assign status_o.out_hold     = out_valid_q & out_stall_i;
  assign out_valid_o           = out_valid_q;
  assign rate_error_filtered_o = out_rate_q;
  assign if_filtered_o         = out_if_q;
  assign sample_taken_o        = out_taken_q;
  assign if_fine_step_o        = out_fine_q;
  assign channel_code_step_o   = out_code_q;

endmodule

@@ rtl/core/rftf_checker.sv @@
// Port-level checks for the tracking filter, bound to the top level.
// Depends on radio_frequency_tracking_filter port names and rftf_pkg step codes.
module rftf_checker
  import rftf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [11:0]        if_filtered_o,
  input logic               sample_taken_o,
  input logic signed [1:0]  if_fine_step_o,
  input logic signed [1:0]  channel_code_step_o
);

  // one packet in flight: a transfer blocks the input on the next cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_step_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((if_fine_step_o == STEP_NONE || if_fine_step_o == STEP_UP
                      || if_fine_step_o == STEP_DOWN)
                     && (channel_code_step_o == STEP_NONE
                         || channel_code_step_o == STEP_UP
                         || channel_code_step_o == STEP_DOWN)))
    else $error("illegal step code");

  a_no_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_taken_o) |-> (channel_code_step_o == STEP_NONE
                                          && if_filtered_o == 12'd0))
    else $error("code step or IF result without sample");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind radio_frequency_tracking_filter rftf_checker u_rftf_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for radio_frequency_tracking_filter.
// Predicts the filtered ppm error, filtered IF estimate and code steps per packet.
// Depends on rftf_pkg and the filter RTL.
module testbench;
  import rftf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PPM_PER_CHIP   = 15625;
  localparam int FIR_DIVISOR    = 512;
  localparam int HOLD_OFF_LEN   = 600;

  typedef struct {
    logic [11:0]        if_est;
    logic [7:0]         errors;
    logic signed [15:0] drift;
    logic [6:0]         length;
  } packet_t;

  typedef struct {
    logic signed [15:0] rate;
    logic [11:0]        if_filt;
    logic               taken;
    logic signed [1:0]  fine;
    logic signed [1:0]  code;
  } correction_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [11:0] if_estimate_i = '0;
  logic [7:0] chip_errors_i = '0;
  logic signed [15:0] drift_count_i = '0;
  logic [6:0] packet_length_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] rate_error_filtered_o;
  logic [11:0] if_filtered_o;
  logic sample_taken_o;
  logic signed [1:0] if_fine_step_o;
  logic signed [1:0] channel_code_step_o;

  radio_frequency_tracking_filter dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .if_estimate_i         (if_estimate_i),
    .chip_errors_i         (chip_errors_i),
    .drift_count_i         (drift_count_i),
    .packet_length_i       (packet_length_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .rate_error_filtered_o (rate_error_filtered_o),
    .if_filtered_o         (if_filtered_o),
    .sample_taken_o        (sample_taken_o),
    .if_fine_step_o        (if_fine_step_o),
    .channel_code_step_o   (channel_code_step_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tracking state mirrored from the block
  cfg_t               cfg;
  logic signed [15:0] error_taps [FILTER_TAPS];
  logic [11:0]        if_taps [FILTER_TAPS];
  logic [15:0]        cooldown;
  int                 tap_weight [FILTER_TAPS] = '{4, 16, 37, 64, 87, 96, 87, 64, 37, 16, 4};

  correction_t correction_queue[$];

  int fail_count = 0;
  int packets_sent = 0;
  int corrections_seen = 0;
  int samples_seen = 0;
  int fine_steps_seen = 0;
  int code_steps_seen = 0;
  int burst_left = 0;
  int hold_off_requests = 0;
  int hold_off_served = 0;

  task automatic reset_tracking_state();
    cfg = '{UPDATE_INTERVAL_RST, PPM_THRESHOLD_RST, CHIP_ERROR_LIMIT_RST,
            IF_HIGH_BOUND_RST, IF_LOW_BOUND_RST};
    for (int k = 0; k < FILTER_TAPS; k++) begin
      error_taps[k] = '0;
      if_taps[k] = (k < FILTER_TAPS - 1) ? IF_IDLE_VALUE : 12'd0;
    end
    cooldown = '0;
  endtask

  function automatic correction_t compute_correction(packet_t p);
    correction_t c;
    int q;
    int sum;
    int filt;
    int unsigned usum;
    logic signed [15:0] sample;
    logic at_interval;
    cooldown = cooldown + 16'd1;
    at_interval = (cooldown == cfg.update_interval);
    sample = '0;
    // zero length skips the division and feeds a zero sample
    if (p.length != 0) begin
      q = (int'(p.drift) * PPM_PER_CHIP) / (int'(p.length) * 8);
      sample = q[15:0];
    end
    for (int k = FILTER_TAPS - 1; k > 0; k--) error_taps[k] = error_taps[k - 1];
    error_taps[0] = sample;
    sum = 0;
    for (int k = 0; k < FILTER_TAPS; k++) sum += int'(error_taps[k]) * tap_weight[k];
    filt = sum / FIR_DIVISOR;
    c.rate = filt[15:0];
    c.fine = STEP_NONE;
    if (at_interval) begin
      if (filt > int'(cfg.ppm_threshold)) c.fine = STEP_UP;
      if (filt < -int'(cfg.ppm_threshold)) c.fine = STEP_DOWN;
    end
    c.taken = 1'b0;
    c.if_filt = '0;
    c.code = STEP_NONE;
    if (p.errors < cfg.chip_error_limit) begin
      c.taken = 1'b1;
      for (int k = FILTER_TAPS - 1; k > 0; k--) if_taps[k] = if_taps[k - 1];
      if_taps[0] = p.if_est;
      usum = 0;
      for (int k = 0; k < FILTER_TAPS; k++) usum += if_taps[k] * tap_weight[k];
      c.if_filt = 12'(usum / FIR_DIVISOR);
      if (at_interval) begin
        if (c.if_filt > cfg.if_high_bound) c.code = STEP_UP;
        if (c.if_filt < cfg.if_low_bound) c.code = STEP_DOWN;
        cooldown = '0;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] register_value(logic [2:0] idx);
    case (idx)
      REG_UPDATE_INTERVAL:  return 32'(cfg.update_interval);
      REG_PPM_THRESHOLD:    return 32'(cfg.ppm_threshold);
      REG_CHIP_ERROR_LIMIT: return 32'(cfg.chip_error_limit);
      REG_IF_HIGH_BOUND:    return 32'(cfg.if_high_bound);
      REG_IF_LOW_BOUND:     return 32'(cfg.if_low_bound);
      default:              return 32'd0;
    endcase
  endfunction

  function automatic packet_t make_packet(int if_est, int errors, int drift, int length);
    packet_t p;
    p.if_est = 12'(if_est);
    p.errors = 8'(errors);
    p.drift = 16'(drift);
    p.length = 7'(length);
    return p;
  endfunction

  function automatic packet_t random_packet();
    packet_t p;
    int kind;
    kind = $urandom_range(0, 19);
    p.if_est = (kind < 16) ? 12'(440 + $urandom_range(0, 120)) : 12'($urandom);
    p.errors = (kind % 5 != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
    if (kind < 14) p.drift = 16'(int'($urandom_range(0, 800)) - 400);
    else if (kind < 18) p.drift = 16'(int'($urandom_range(0, 12000)) - 6000);
    else p.drift = 16'($urandom);
    if (kind == 19 && $urandom_range(0, 3) == 0) p.length = '0;
    else if (kind < 16) p.length = 7'($urandom_range(16, 127));
    else p.length = 7'($urandom_range(1, 127));
    return p;
  endfunction

  task automatic check_register(logic [2:0] idx);
    logic [31:0] want;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = register_value(idx);
    if (prdata !== want) begin
      $error("register %0d readback: expected %0d, got %0d", idx, want, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_UPDATE_INTERVAL:  cfg.update_interval = value[15:0];
      REG_PPM_THRESHOLD:    cfg.ppm_threshold = value[14:0];
      REG_CHIP_ERROR_LIMIT: cfg.chip_error_limit = value[7:0];
      REG_IF_HIGH_BOUND:    cfg.if_high_bound = value[11:0];
      REG_IF_LOW_BOUND:     cfg.if_low_bound = value[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_register(idx);
  endtask

  // Place the interval a few packets past the current cooldown count
  task automatic configure(int unsigned ahead, int unsigned thr, int unsigned limit,
                           int unsigned high, int unsigned low);
    write_register(REG_UPDATE_INTERVAL, 32'(cooldown + ahead));
    write_register(REG_PPM_THRESHOLD, thr);
    write_register(REG_CHIP_ERROR_LIMIT, limit);
    write_register(REG_IF_HIGH_BOUND, high);
    write_register(REG_IF_LOW_BOUND, low);
  endtask

  task automatic offer_packet(packet_t p);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    if_estimate_i <= p.if_est;
    chip_errors_i <= p.errors;
    drift_count_i <= p.drift;
    packet_length_i <= p.length;
    do @(posedge clk_i); while (in_stall_o);
    correction_queue.push_back(compute_correction(p));
    packets_sent++;
    burst_left--;
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (correction_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_register_access();
    for (int i = 0; i <= int'(REG_IF_LOW_BOUND); i++) check_register(3'(i));
    // out-of-range values must come back masked to the register width
    for (int i = 0; i <= int'(REG_IF_LOW_BOUND); i++) write_register(3'(i), 32'hFFFF_FFFF);
    write_register(REG_UPDATE_INTERVAL, 32'(UPDATE_INTERVAL_RST));
    write_register(REG_PPM_THRESHOLD, 32'(PPM_THRESHOLD_RST));
    write_register(REG_CHIP_ERROR_LIMIT, 32'(CHIP_ERROR_LIMIT_RST));
    write_register(REG_IF_HIGH_BOUND, 32'(IF_HIGH_BOUND_RST));
    write_register(REG_IF_LOW_BOUND, 32'(IF_LOW_BOUND_RST));
  endtask

  task automatic test_directed_packets();
    offer_packet(make_packet(500, 0, 0, 64));
    offer_packet(make_packet(4095, 255, 32767, 1));
    offer_packet(make_packet(0, 0, -32768, 1));
    offer_packet(make_packet(0, 25, -32768, 0));
    offer_packet(make_packet(4095, 24, 32767, 0));
    offer_packet(make_packet(500, 0, 1234, 127));
    offer_packet(make_packet(2048, 128, -1, 127));
    offer_packet(make_packet(1, 0, 1, 1));
    repeat (6) offer_packet(make_packet(520, 10, 200, 100));
    // fifteenth packet lands on the default update interval
    offer_packet(make_packet(4095, 0, 2000, 20));
    wait_until_drained();
  endtask

  task automatic test_step_cases();
    configure(1, 0, 25, 520, 480);
    offer_packet(make_packet(4095, 0, 3000, 16));
    offer_packet(make_packet(4095, 0, 3000, 16));
    repeat (3) offer_packet(make_packet(0, 0, -3000, 16));
    offer_packet(make_packet(500, 0, 0, 64));
    // too many chip errors at the interval: counter keeps running
    offer_packet(make_packet(500, 255, 0, 64));
    offer_packet(make_packet(500, 0, 0, 64));
    wait_until_drained();
    configure(1, 32'hFFFF_FFFF, 25, 520, 480);
    offer_packet(make_packet(4095, 0, 32767, 1));
    wait_until_drained();
  endtask

  task automatic test_config_extremes();
    configure(1, 0, 255, 4095, 0);
    repeat (40) offer_packet(random_packet());
    wait_until_drained();
    configure(3, 32767, 0, 0, 4095);
    repeat (40) offer_packet(random_packet());
    wait_until_drained();
    // inverted bounds: both compares hit and the down step wins
    configure(2, 200, 255, 0, 4095);
    repeat (40) offer_packet(random_packet());
    wait_until_drained();
    write_register(REG_UPDATE_INTERVAL, 32'd65535);
    repeat (40) offer_packet(random_packet());
    wait_until_drained();
    configure(1, 1000, 1, 4095, 4095);
    repeat (40) offer_packet(random_packet());
    wait_until_drained();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 11; phase++) begin
      configure($urandom_range(1, 6), $urandom_range(0, 1500), $urandom_range(20, 255),
                500 + $urandom_range(0, 40), 500 - $urandom_range(0, 40));
      repeat (60) offer_packet(random_packet());
      wait_until_drained();
    end
  endtask

  task automatic test_output_backpressure();
    configure(2, 500, 200, 510, 490);
    hold_off_requests++;
    repeat (24) offer_packet(random_packet());
    wait_until_drained();
  endtask

  // Receiver stall pattern, with a long hold-off on request
  int stall_mode = 0;
  int stall_span = 0;
  int stall_phase = 0;
  int hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_left = HOLD_OFF_LEN;
    end
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(50, 400);
    end
    stall_span--;
    stall_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ((stall_phase % 7) < 3);
      endcase
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_corrections
    correction_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (correction_queue.size() == 0) begin
        $error("result transfer with no packet outstanding");
        fail_count++;
      end else begin
        want = correction_queue.pop_front();
        check_field("rate_error_filtered", want.rate, rate_error_filtered_o);
        check_field("if_filtered", want.if_filt, if_filtered_o);
        check_field("sample_taken", want.taken, sample_taken_o);
        check_field("if_fine_step", want.fine, if_fine_step_o);
        check_field("channel_code_step", want.code, channel_code_step_o);
      end
      corrections_seen++;
      if (sample_taken_o) samples_seen++;
      if (if_fine_step_o != STEP_NONE) fine_steps_seen++;
      if (channel_code_step_o != STEP_NONE) code_steps_seen++;
    end
  end

  // Abort when no transfer of any kind happens for too long
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_tracking_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_access();
    test_directed_packets();
    test_step_cases();
    test_config_extremes();
    test_random_traffic();
    test_output_backpressure();
    wait_until_drained();
    $display("Covered %0d packets and %0d checked results across register extremes",
             packets_sent, corrections_seen);
    $display("IF samples taken %0d, fine steps %0d, channel code steps %0d",
             samples_seen, fine_steps_seen, code_steps_seen);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
